### sv/blfs_pkg.sv
package blfs_pkg;

    // Stack capacity and derived widths
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 7;
    localparam int DW    = 32;

    // Request codes
    localparam logic [2:0] REQ_PUSH    = 3'd0;
    localparam logic [2:0] REQ_POP     = 3'd1;
    localparam logic [2:0] REQ_TOP     = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_REVERSE = 3'd4;

    // Word returned by a top on an empty stack
    localparam logic [DW-1:0] TOP_FAIL_WORD = 32'hBF80_0000;

    typedef struct packed {
        logic [2:0]    req_type;
        logic [DW-1:0] push_value;
    } t_req_item;

    typedef struct packed {
        logic [DW-1:0] read_value;
        logic          fault;
        logic [CW-1:0] count;
        logic          is_empty;
        logic          is_full;
    } t_rsp_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REV_RD_LO,
        ST_REV_RD_HI,
        ST_REV_WR_LO,
        ST_REV_WR_HI
    } t_state;

endpackage

### sv/bounded_lifo_stack.sv
// Bounded LIFO stack of 32-bit words, capacity blfs_pkg::DEPTH.
// Input channel: i_in_valid / o_in_stall carry one request (push, pop, top,
// clear, reverse) with its push word. Output channel: o_out_valid /
// i_out_stall carry exactly one result per request: read word, fault flag,
// count after the request, empty and full flags.
// The result is valid the cycle after the request transfer for push,
// clear, no-op reverse, failed requests and unused codes; a successful
// pop or top first passes ST_READ to wait on the registered RAM read.
// Throughput: one request per cycle for push and clear while the receiver
// does not stall; pop and top hold off the input in ST_READ. Reverse swaps
// entries pairwise through the single write port, input held off meanwhile.
// The output register frees the input side: a new request transfers in the
// same cycle the previous result leaves. While the receiver stalls with a
// result pending, the result holds and o_in_stall stays high.
// Reset empties the stack (count 0) at once; the word RAM is not cleared
// and entries are only read after a push wrote them.
module bounded_lifo_stack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  blfs_pkg::t_req_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output blfs_pkg::t_rsp_item  o_out_data
);

    localparam int AW = blfs_pkg::AW;
    localparam int CW = blfs_pkg::CW;
    localparam int DW = blfs_pkg::DW;

    blfs_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [AW-1:0]       r_lo, n_lo;
    logic [AW-1:0]       r_hi, n_hi;
    logic [DW-1:0]       r_tmp, n_tmp;
    logic                r_out_valid, n_out_valid;
    blfs_pkg::t_rsp_item r_out_data, n_out_data;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic in_ready;
    logic in_xfer;
    logic is_empty;
    logic is_full;
    logic [AW-1:0] lo_inc;
    logic [AW-1:0] hi_dec;

    // Build one result item from the word, fault and resulting fill
    function automatic blfs_pkg::t_rsp_item mk_rsp(
        input logic [DW-1:0] rd,
        input logic          flt,
        input logic [CW-1:0] fl
    );
        blfs_pkg::t_rsp_item rsp;
        rsp.read_value = rd;
        rsp.fault      = flt;
        rsp.count      = fl;
        rsp.is_empty   = (fl == '0);
        rsp.is_full    = (fl == CW'(blfs_pkg::DEPTH));
        return rsp;
    endfunction

    blfs_ram #(
        .WIDTH(DW),
        .DEPTH(blfs_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Take a request only when idle and the output slot is free or draining
    assign in_ready   = (r_state == blfs_pkg::ST_IDLE) && (!r_out_valid || !i_out_stall);
    assign in_xfer    = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    assign is_empty = (r_fill == '0);
    assign is_full  = (r_fill == CW'(blfs_pkg::DEPTH));
    assign lo_inc   = r_lo + AW'(1);
    assign hi_dec   = r_hi - AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blfs_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_tmp      <= n_tmp;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_tmp       = r_tmp;
        n_out_data  = r_out_data;
        // Drop the pending result once the receiver takes it
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[AW-1:0];
        ram_wdata   = i_in_data.push_value;
        // Top of stack; wraps to DEPTH-1 when full
        ram_raddr   = r_fill[AW-1:0] - AW'(1);

        unique case (r_state)
            blfs_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.req_type)
                        blfs_pkg::REQ_PUSH: begin
                            if (is_full) begin
                                n_out_data  = mk_rsp('0, 1'b1, r_fill);
                            end else begin
                                ram_we      = 1'b1;
                                n_fill      = r_fill + CW'(1);
                                n_out_data  = mk_rsp('0, 1'b0, r_fill + CW'(1));
                            end
                            n_out_valid = 1'b1;
                        end
                        blfs_pkg::REQ_POP: begin
                            if (is_empty) begin
                                n_out_data  = mk_rsp('0, 1'b1, r_fill);
                                n_out_valid = 1'b1;
                            end else begin
                                n_fill  = r_fill - CW'(1);
                                n_state = blfs_pkg::ST_READ;
                            end
                        end
                        blfs_pkg::REQ_TOP: begin
                            if (is_empty) begin
                                n_out_data  = mk_rsp(blfs_pkg::TOP_FAIL_WORD, 1'b1, r_fill);
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = blfs_pkg::ST_READ;
                            end
                        end
                        blfs_pkg::REQ_CLEAR: begin
                            n_fill      = '0;
                            n_out_data  = mk_rsp('0, 1'b0, '0);
                            n_out_valid = 1'b1;
                        end
                        blfs_pkg::REQ_REVERSE: begin
                            if (r_fill > CW'(1)) begin
                                n_lo    = '0;
                                n_hi    = r_fill[AW-1:0] - AW'(1);
                                n_state = blfs_pkg::ST_REV_RD_LO;
                            end else begin
                                n_out_data  = mk_rsp('0, 1'b0, r_fill);
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_out_data  = mk_rsp('0, 1'b0, r_fill);
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            blfs_pkg::ST_READ: begin
                // Word read in the accept cycle arrives now; fill already updated
                n_out_data  = mk_rsp(ram_rdata, 1'b0, r_fill);
                n_out_valid = 1'b1;
                n_state     = blfs_pkg::ST_IDLE;
            end
            blfs_pkg::ST_REV_RD_LO: begin
                ram_raddr = r_lo;
                n_state   = blfs_pkg::ST_REV_RD_HI;
            end
            blfs_pkg::ST_REV_RD_HI: begin
                ram_raddr = r_hi;
                n_tmp     = ram_rdata;
                n_state   = blfs_pkg::ST_REV_WR_LO;
            end
            blfs_pkg::ST_REV_WR_LO: begin
                // Upper word lands in the lower slot
                ram_we    = 1'b1;
                ram_waddr = r_lo;
                ram_wdata = ram_rdata;
                n_state   = blfs_pkg::ST_REV_WR_HI;
            end
            blfs_pkg::ST_REV_WR_HI: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                ram_wdata = r_tmp;
                n_lo      = lo_inc;
                n_hi      = hi_dec;
                if (lo_inc < hi_dec) begin
                    n_state = blfs_pkg::ST_REV_RD_LO;
                end else begin
                    n_out_data  = mk_rsp('0, 1'b0, r_fill);
                    n_out_valid = 1'b1;
                    n_state     = blfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = blfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sv/blfs_ram.sv
module blfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### bench/bounded_lifo_stack_checker.sv
`timescale 1ns / 1ps

module bounded_lifo_stack_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  blfs_pkg::t_req_item i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  blfs_pkg::t_rsp_item i_out_data,
    output int                  o_fail_count,
    output int                  o_open,
    output int                  o_checked,
    output int                  o_faults,
    output int                  o_full_seen
);

    // Shadow copy of the stack contents and fill level
    logic [blfs_pkg::DW-1:0] stack_words [blfs_pkg::DEPTH];
    int                      stack_fill = 0;
    blfs_pkg::t_rsp_item     rsp_expected [$];

    // Apply one request to the shadow stack and return the response it owes
    function automatic blfs_pkg::t_rsp_item predict_response(blfs_pkg::t_req_item rq);
        blfs_pkg::t_rsp_item     rsp;
        logic [blfs_pkg::DW-1:0] tmp;
        int                      lo;
        int                      hi;
        rsp = '0;
        case (rq.req_type)
            blfs_pkg::REQ_PUSH: begin
                if (stack_fill < blfs_pkg::DEPTH) begin
                    stack_words[stack_fill] = rq.push_value;
                    stack_fill++;
                end else begin
                    rsp.fault = 1'b1;
                end
            end
            blfs_pkg::REQ_POP: begin
                if (stack_fill > 0) begin
                    stack_fill--;
                    rsp.read_value = stack_words[stack_fill];
                end else begin
                    rsp.fault = 1'b1;
                end
            end
            blfs_pkg::REQ_TOP: begin
                if (stack_fill > 0) begin
                    rsp.read_value = stack_words[stack_fill - 1];
                end else begin
                    rsp.fault      = 1'b1;
                    rsp.read_value = blfs_pkg::TOP_FAIL_WORD;
                end
            end
            blfs_pkg::REQ_CLEAR: begin
                stack_fill = 0;
            end
            blfs_pkg::REQ_REVERSE: begin
                lo = 0;
                hi = stack_fill - 1;
                while (lo < hi) begin
                    tmp             = stack_words[lo];
                    stack_words[lo] = stack_words[hi];
                    stack_words[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            default: ;
        endcase
        rsp.count    = blfs_pkg::CW'(stack_fill);
        rsp.is_empty = (stack_fill == 0);
        rsp.is_full  = (stack_fill == blfs_pkg::DEPTH);
        return rsp;
    endfunction

    function automatic int field_bad(string name, logic [blfs_pkg::DW-1:0] want,
                                     logic [blfs_pkg::DW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        blfs_pkg::t_rsp_item want;
        int                  bad;
        if (i_rst_n) begin
            // Retire a result first, then log the request that transfers at this edge
            if (i_out_valid && !i_out_stall) begin
                if (rsp_expected.size() == 0) begin
                    $error("result with no request outstanding: %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = rsp_expected.pop_front();
                    bad  = 0;
                    bad += field_bad("read_value", want.read_value, i_out_data.read_value);
                    bad += field_bad("fault", blfs_pkg::DW'(want.fault),
                                     blfs_pkg::DW'(i_out_data.fault));
                    bad += field_bad("count", blfs_pkg::DW'(want.count),
                                     blfs_pkg::DW'(i_out_data.count));
                    bad += field_bad("is_empty", blfs_pkg::DW'(want.is_empty),
                                     blfs_pkg::DW'(i_out_data.is_empty));
                    bad += field_bad("is_full", blfs_pkg::DW'(want.is_full),
                                     blfs_pkg::DW'(i_out_data.is_full));
                    o_fail_count <= o_fail_count + bad;
                    o_checked    <= o_checked + 1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = predict_response(i_in_data);
                rsp_expected.push_back(want);
                if (want.fault) begin
                    o_faults <= o_faults + 1;
                end
                if (want.is_full) begin
                    o_full_seen <= o_full_seen + 1;
                end
            end
            o_open <= rsp_expected.size();
        end
    end

endmodule

### bench/tb_bounded_lifo_stack.sv
`timescale 1ns / 1ps

module tb_bounded_lifo_stack;

    // Kinds of request sequence in the random part
    typedef enum {EP_MIXED, EP_FILL, EP_DRAIN, EP_NOISE} t_episode;

    // Receiver back-pressure patterns
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    localparam int RANDOM_ITEMS = 600;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    blfs_pkg::t_req_item i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    blfs_pkg::t_rsp_item o_out_data;

    int          fail_count;
    int          open_cnt;
    int          checked_cnt;
    int          fault_cnt;
    int          full_cnt;

    // Sender bookkeeping
    int          burst_left = 0;
    int          n_sent [8];
    int          n_counted = 0;

    // Receiver pattern state
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;

    bounded_lifo_stack u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    bounded_lifo_stack_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_open       (open_cnt),
        .o_checked    (checked_cnt),
        .o_faults     (fault_cnt),
        .o_full_seen  (full_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: switch between stall patterns at random so that
    // back-pressure lands on every phase of a pop, a top and a reverse.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 6);
                // Long runs: flip only now and then
                default:     i_out_stall <= ($urandom_range(0, 7) == 0) ? ~i_out_stall
                                                                        : i_out_stall;
            endcase
        end
    end

    // Word mix: all-zero, all-one and one-hot patterns among plain random words
    function automatic logic [blfs_pkg::DW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return blfs_pkg::DW'(1) << $urandom_range(0, blfs_pkg::DW - 1);
            default: return $urandom;
        endcase
    endfunction

    // Mixed traffic leans toward push so the stack climbs toward full now and then
    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return blfs_pkg::REQ_PUSH;
        if (r < 67) return blfs_pkg::REQ_POP;
        if (r < 82) return blfs_pkg::REQ_TOP;
        if (r < 86) return blfs_pkg::REQ_CLEAR;
        return blfs_pkg::REQ_REVERSE;
    endfunction

    // Present one request and hold it until it transfers; at the end of a
    // burst drop valid for a random gap and pick the next burst length.
    task automatic send_req(input logic [2:0] op, input logic [blfs_pkg::DW-1:0] word);
        int gap;
        i_in_valid          <= 1'b1;
        i_in_data.req_type   <= op;
        i_in_data.push_value <= word;
        do @(posedge i_clk); while (o_in_stall);
        n_sent[op]++;
        if (op <= blfs_pkg::REQ_REVERSE) begin
            n_counted++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // Mostly short bursts, sometimes a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (open_cnt != 0);
    endtask

    task automatic run_episode(input t_episode kind);
        case (kind)
            EP_MIXED: begin
                repeat ($urandom_range(10, 40)) send_req(pick_op(), rand_word());
            end
            EP_FILL: begin
                // Overfill to hit the full-stack fault, then read and flip it
                repeat (blfs_pkg::DEPTH + $urandom_range(1, 3)) begin
                    send_req(blfs_pkg::REQ_PUSH, rand_word());
                end
                send_req(blfs_pkg::REQ_TOP, rand_word());
                send_req(blfs_pkg::REQ_REVERSE, rand_word());
                send_req(blfs_pkg::REQ_TOP, rand_word());
            end
            EP_DRAIN: begin
                // Empty it out past the bottom, with a few peeks on the way
                send_req(blfs_pkg::REQ_REVERSE, rand_word());
                repeat (blfs_pkg::DEPTH + $urandom_range(1, 2)) begin
                    send_req(($urandom_range(0, 4) == 0) ? blfs_pkg::REQ_TOP
                                                         : blfs_pkg::REQ_POP, rand_word());
                end
                send_req(blfs_pkg::REQ_TOP, rand_word());
            end
            default: begin
                // Any code, unused ones included
                repeat ($urandom_range(3, 10)) send_req(3'($urandom_range(0, 7)), rand_word());
            end
        endcase
    endtask

    initial begin
        int r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: faults on an empty stack, no-op clear and reverse,
        // unused codes, word extremes, and a small reverse with its readback.
        send_req(blfs_pkg::REQ_TOP, '1);
        send_req(blfs_pkg::REQ_POP, '1);
        send_req(blfs_pkg::REQ_CLEAR, '0);
        send_req(blfs_pkg::REQ_REVERSE, '0);
        for (int c = blfs_pkg::REQ_REVERSE + 1; c < 8; c++) begin
            send_req(3'(c), '1);
        end
        send_req(blfs_pkg::REQ_PUSH, '0);
        send_req(blfs_pkg::REQ_PUSH, '1);
        send_req(blfs_pkg::REQ_PUSH, 32'h8000_0001);
        send_req(blfs_pkg::REQ_TOP, '0);
        send_req(blfs_pkg::REQ_REVERSE, '1);
        send_req(blfs_pkg::REQ_TOP, '0);
        send_req(blfs_pkg::REQ_POP, '0);
        send_req(blfs_pkg::REQ_POP, '0);
        send_req(blfs_pkg::REQ_POP, '0);
        send_req(blfs_pkg::REQ_POP, '0);
        send_req(blfs_pkg::REQ_PUSH, 32'h1234_5678);
        send_req(blfs_pkg::REQ_PUSH, 32'h5A5A_A5A5);
        send_req(blfs_pkg::REQ_REVERSE, '0);
        send_req(blfs_pkg::REQ_CLEAR, '1);
        send_req(blfs_pkg::REQ_TOP, '0);
        drain_results();

        // Random: well-formed fill and drain runs, mixed traffic, some noise
        n_counted = 0;
        while (n_counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                run_episode(EP_MIXED);
            end else if (r < 65) begin
                run_episode(EP_FILL);
            end else if (r < 85) begin
                run_episode(EP_DRAIN);
            end else begin
                run_episode(EP_NOISE);
            end
            if ($urandom_range(0, 4) == 0) begin
                drain_results();
            end
        end

        // Let the last results come out, then watch for strays
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("covered %0d push, %0d pop, %0d top, %0d clear, %0d reverse, %0d unused-code requests",
                 n_sent[blfs_pkg::REQ_PUSH], n_sent[blfs_pkg::REQ_POP],
                 n_sent[blfs_pkg::REQ_TOP], n_sent[blfs_pkg::REQ_CLEAR],
                 n_sent[blfs_pkg::REQ_REVERSE], n_sent[5] + n_sent[6] + n_sent[7]);
        $display("checked %0d results, %0d of them faults, %0d with the stack full",
                 checked_cnt, fault_cnt, full_cnt);
        if (fail_count == 0 && open_cnt == 0) begin
            $display("bounded_lifo_stack regression: pass");
        end else begin
            $display("bounded_lifo_stack regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("bounded_lifo_stack regression: fail");
        $finish;
    end

endmodule
